// ----- rtl/cms_pkg.sv -----
package cms_pkg;

  // protocol control bytes
  localparam logic [7:0] PCI_FIRST  = 8'h10;
  localparam logic [7:0] PCI_CONSEC = 8'h20;
  localparam logic [3:0] SEQ_MASK   = 4'hF;
  localparam logic [7:0] MIN_LENGTH = 8'd8;

  // slot counts of first and consecutive frames
  localparam logic [2:0] CAP_FIRST  = 3'd6;
  localparam logic [2:0] CAP_CONSEC = 3'd7;

  // input transfer
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] message_length;
  } in_item_t;

  // output transfer
  typedef struct packed {
    logic [63:0] frame_data;
    logic [5:0]  frame_no;
    logic        last_frame;
    logic [15:0] running_sum;
  } out_item_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] slot;
    logic       start;
    logic       emit;
    logic       last;
    logic       first;
    logic [5:0] index;
    logic [7:0] pci;
    logic [7:0] length;
  } op_t;

endpackage

// ----- rtl/can_multiframe_segmenter.sv -----
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o   | cms_pkg::in_item_t  in_item_i
// out     | output    | out_valid_o / out_ready_i | cms_pkg::out_item_t out_item_o
//
// one payload byte is taken per cycle while the queue has room; a frame shows on the output
// once the byte that fills or ends it has passed the queue and then the output register,
// and waits longer only while earlier frames wait on the receiver
// the front end classifies each byte in the cycle of its transfer, the back end
// packs one queued byte per cycle, so sustained rate is one byte per cycle, while the output takes frames
// a stalled output backs up the queue; bytes that make no frame still drain
// reset clears all counters but the sequence number, which it sets to 1, and clears the queue and the output valid
module can_multiframe_segmenter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cms_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cms_pkg::out_item_t out_item_o
);

  logic         fq_valid, fq_ready;
  cms_pkg::op_t fq_op;
  logic         qb_valid, qb_ready;
  cms_pkg::op_t qb_op;

  // byte classification
  cms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .op_valid_o (fq_valid),
    .op_ready_i (fq_ready),
    .op_o       (fq_op)
  );

  // decoupling queue
  cms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_op_i    (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_op_o     (qb_op)
  );

  // frame assembly
  cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (qb_valid),
    .op_ready_o  (qb_ready),
    .op_i        (qb_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/cms_front.sv -----
module cms_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cms_pkg::in_item_t in_item_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output cms_pkg::op_t     op_o
);

  logic [7:0] bytes_left_q, bytes_left_d;
  logic [2:0] fill_q, fill_d;
  logic [5:0] frames_q, frames_d;
  logic [3:0] seq_q, seq_d;
  logic [7:0] length_q, length_d;

  logic       idle;
  logic [7:0] len_clamped;
  logic [7:0] left_cur, left_nx;
  logic [2:0] fill_cur, fill_nx;
  logic [5:0] frames_cur;
  logic [3:0] seq_cur;
  logic [7:0] length_cur;
  logic       first, last, emit;
  logic       accept;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i & op_ready_i;

  // message start picks up a fresh length, clears the fill and frame counters and sets the sequence to 1
  always_comb begin
    idle        = (bytes_left_q == 8'd0);
    len_clamped = (in_item_i.message_length < cms_pkg::MIN_LENGTH) ?
                  cms_pkg::MIN_LENGTH : in_item_i.message_length;
    left_cur    = idle ? len_clamped : bytes_left_q;
    fill_cur    = idle ? 3'd0 : fill_q;
    frames_cur  = idle ? 6'd0 : frames_q;
    seq_cur     = idle ? 4'd1 : seq_q;
    length_cur  = idle ? len_clamped : length_q;
    fill_nx     = fill_cur + 3'd1;
    left_nx     = left_cur - 8'd1;
    first       = (frames_cur == 6'd0);
    last        = (left_nx == 8'd0);
    emit        = last | (fill_nx == (first ? cms_pkg::CAP_FIRST : cms_pkg::CAP_CONSEC));
  end

  // classified byte for the back end
  always_comb begin
    op_o.data   = in_item_i.payload_byte;
    op_o.slot   = fill_cur;
    op_o.start  = idle;
    op_o.emit   = emit;
    op_o.last   = last;
    op_o.first  = first;
    op_o.index  = frames_cur;
    op_o.pci    = first ? cms_pkg::PCI_FIRST
                        : (cms_pkg::PCI_CONSEC | {4'd0, seq_cur & cms_pkg::SEQ_MASK});
    op_o.length = length_cur;
  end

  // counter updates
  always_comb begin
    bytes_left_d = left_nx;
    fill_d       = emit ? 3'd0 : fill_nx;
    frames_d     = frames_cur + {5'd0, emit};
    seq_d        = seq_cur + {3'd0, emit & ~first};
    length_d     = length_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 8'd0;
      fill_q       <= 3'd0;
      frames_q     <= 6'd0;
      seq_q        <= 4'd1;
      length_q     <= 8'd0;
    end else if (accept) begin
      bytes_left_q <= bytes_left_d;
      fill_q       <= fill_d;
      frames_q     <= frames_d;
      seq_q        <= seq_d;
      length_q     <= length_d;
    end
  end

endmodule

// ----- rtl/cms_queue.sv -----
module cms_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  cms_pkg::op_t push_op_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output cms_pkg::op_t pop_op_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  cms_pkg::op_t    entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entries_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (push && !pop) count_d = count_q + CntW'(1);
    else if (pop && !push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_op_i;
  end

endmodule

// ----- rtl/cms_back.sv -----
module cms_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  cms_pkg::op_t      op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cms_pkg::out_item_t out_item_o
);

  logic [55:0]        buffer_q, buffer_d;
  logic [15:0]        sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  cms_pkg::out_item_t out_q, out_d;

  logic [5:0]  shift_amt;
  logic [55:0] buffer_new;
  logic [15:0] sum_new;
  logic        pop;

  // a byte that makes no frame never waits on the output
  assign op_ready_o  = ~out_valid_q | out_ready_i | ~op_i.emit;
  assign pop         = op_valid_i & op_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // pack byte into its slot and accumulate the sum
  always_comb begin
    shift_amt  = 6'd48 - {op_i.slot, 3'b000};
    buffer_new = buffer_q | ({48'd0, op_i.data} << shift_amt);
    sum_new    = (op_i.start ? 16'd0 : sum_q) + {8'd0, op_i.data};
  end

  // frame assembly and output register
  always_comb begin
    buffer_d    = buffer_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (pop) begin
      sum_d    = sum_new;
      buffer_d = op_i.emit ? 56'd0 : buffer_new;
      if (op_i.emit) begin
        out_d.frame_data  = op_i.first ? {op_i.pci, op_i.length, buffer_new[55:8]}
                                       : {op_i.pci, buffer_new};
        out_d.frame_no    = op_i.index;
        out_d.last_frame  = op_i.last;
        out_d.running_sum = sum_new;
        out_valid_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_q    <= 56'd0;
      sum_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      buffer_q    <= buffer_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;

  // tracks the segmenter state and holds the frames still owed by the block
  class frame_predictor;
    logic [7:0]         bytes_due;
    logic [2:0]         fill;
    logic [55:0]        frame_bytes;
    logic [3:0]         seq;
    logic [5:0]         sent;
    logic [15:0]        sum;
    logic [7:0]         msg_len;
    cms_pkg::out_item_t expected_frames[$];
    int                 mismatches;
    int                 n_bytes;
    int                 n_frames;
    int                 n_messages;
    int                 n_wraps;
    int                 max_index;

    function new();
      bytes_due   = '0;
      fill        = '0;
      frame_bytes = '0;
      seq         = 4'd1;
      sent        = '0;
      sum         = '0;
      msg_len     = '0;
      mismatches  = 0;
      n_bytes     = 0;
      n_frames    = 0;
      n_messages  = 0;
      n_wraps     = 0;
      max_index   = 0;
    endfunction

    // one accepted byte; queues a frame when the byte fills or ends one
    function void note_byte(cms_pkg::in_item_t it);
      logic [2:0]         cap;
      logic               last;
      int                 sh;
      cms_pkg::out_item_t fr;
      n_bytes++;
      if (bytes_due == 8'd0) begin
        msg_len     = (it.message_length < cms_pkg::MIN_LENGTH) ?
                      cms_pkg::MIN_LENGTH : it.message_length;
        bytes_due   = msg_len;
        sum         = '0;
        fill        = '0;
        frame_bytes = '0;
        seq         = 4'd1;
        sent        = '0;
        n_messages++;
      end
      sum         = sum + 16'(it.payload_byte);
      sh          = 48 - 8 * int'(fill);
      frame_bytes = frame_bytes | (56'(it.payload_byte) << sh);
      fill        = fill + 3'd1;
      bytes_due   = bytes_due - 8'd1;
      cap         = (sent == 6'd0) ? cms_pkg::CAP_FIRST : cms_pkg::CAP_CONSEC;
      last        = (bytes_due == 8'd0);
      if (fill != cap && !last) return;
      if (sent == 6'd0) begin
        fr.frame_data = {cms_pkg::PCI_FIRST, msg_len, frame_bytes[55:8]};
      end else begin
        fr.frame_data = {cms_pkg::PCI_CONSEC | {4'h0, seq & cms_pkg::SEQ_MASK}, frame_bytes};
        if (seq == 4'd15) n_wraps++;
        seq = seq + 4'd1;
      end
      fr.frame_no    = sent;
      fr.last_frame  = last;
      fr.running_sum = sum;
      expected_frames.push_back(fr);
      if (int'(sent) > max_index) max_index = int'(sent);
      sent        = sent + 6'd1;
      fill        = '0;
      frame_bytes = '0;
    endfunction

    // one accepted frame against the oldest one owed
    function void check_frame(cms_pkg::out_item_t act);
      cms_pkg::out_item_t exp_fr;
      n_frames++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: data %h index %0d last %0b sum %h",
                   act.frame_data, act.frame_no, act.last_frame, act.running_sum);
        return;
      end
      exp_fr = expected_frames.pop_front();
      if (act.frame_data !== exp_fr.frame_data || act.frame_no !== exp_fr.frame_no ||
          act.last_frame !== exp_fr.last_frame || act.running_sum !== exp_fr.running_sum) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"frame mismatch: exp data %h index %0d last %0b sum %h,",
                    " got data %h index %0d last %0b sum %h"},
                   exp_fr.frame_data, exp_fr.frame_no, exp_fr.last_frame, exp_fr.running_sum,
                   act.frame_data, act.frame_no, act.last_frame, act.running_sum);
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  cms_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  cms_pkg::out_item_t out_item_o;

  frame_predictor segmenter_model = new();
  int             send_idle_pct   = 0;
  int             recv_stall_pct  = 0;
  int             phase_bytes;

  can_multiframe_segmenter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // transfer monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) segmenter_model.note_byte(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) segmenter_model.check_frame(out_item_o);
  end

  // hang guard
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] data, input logic [7:0] len_field);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i                <= 1'b1;
    in_item_i.payload_byte    <= data;
    in_item_i.message_length  <= len_field;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // whole message; fixed_byte below zero gives random payload
  task automatic send_message(input logic [7:0] len_field, input int fixed_byte);
    int         count;
    logic [7:0] data;
    count = (len_field < cms_pkg::MIN_LENGTH) ? int'(cms_pkg::MIN_LENGTH) : int'(len_field);
    for (int i = 0; i < count; i++) begin
      if (fixed_byte >= 0) data = 8'(fixed_byte);
      else if ($urandom_range(9) == 0) data = $urandom_range(1) ? 8'hFF : 8'h00;
      else data = 8'($urandom_range(255));
      // length field only counts on the opening byte
      send_byte(data, (i == 0) ? len_field : 8'($urandom_range(255)));
    end
    phase_bytes += count;
  endtask

  // mostly short messages, some long enough to wrap the sequence number
  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(30));
    if (r < 85) return 8'($urandom_range(127, 31));
    return 8'($urandom_range(255, 128));
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short length with all-ones bytes, then exact length with zero bytes, then length 255 with random bytes
    phase_bytes = 0;
    send_message(8'd0, 255);
    send_message(8'd8, 0);
    send_message(8'd255, -1);

    // random messages across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 340) send_message(pick_length(), -1);
    end
    in_valid_i <= 1'b0;

    // drain
    while (segmenter_model.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d bytes in %0d messages, %0d frames checked",
             segmenter_model.n_bytes, segmenter_model.n_messages, segmenter_model.n_frames);
    $display("highest frame index %0d, %0d sequence wraps, %0d mismatches",
             segmenter_model.max_index, segmenter_model.n_wraps, segmenter_model.mismatches);
    if (segmenter_model.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
